// File: rtl/cda_pkg.sv
`timescale 1ns / 1ps
package cda_pkg;

	localparam int BASE_YEAR = 1900;
	localparam int YEAR_SPAN = 256;
	localparam int REF_DAY   = 1;
	localparam int REF_MONTH = 1;
	localparam int LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;

	typedef logic [1:0]  op_t;
	typedef logic [4:0]  day_t;
	typedef logic [3:0]  month_t;
	typedef logic [11:0] year_t;
	typedef logic [8:0]  doy_t;
	typedef logic [8:0]  off_t;
	typedef logic [17:0] dnum_t;
	typedef logic [15:0] cnt_t;
	typedef logic signed [18:0] diff_t;
	typedef logic [2:0]  wday_t;

	localparam op_t OP_ASSIGN = 2'd0;
	localparam op_t OP_ADD    = 2'd1;
	localparam op_t OP_SUB    = 2'd2;
	localparam op_t OP_CMP    = 2'd3;

	localparam day_t MONTH_LEN [0:15] = '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};
	localparam doy_t CUM_DAYS [0:15] = '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0};

	typedef struct packed {
		logic load;
		logic calc_held;
		logic calc_given;
		logic exec;
		logic year_step;
		logic month_step;
		logic publish;
	} cda_cmd_t;

	typedef struct packed {
		logic conv;
		logic year_done;
		logic month_done;
		logic out_free;
	} cda_status_t;

	// floor(x / 25) for x below 1024, by reciprocal
	function automatic logic [5:0] div25(input logic [9:0] x);
		logic [21:0] p;
		p = {12'd0, x} * 22'd2622;
		return p[21:16];
	endfunction

	function automatic logic leap(input year_t y);
		logic [5:0]  q100;
		logic [5:0]  q400;
		logic [11:0] h100;
		logic [11:0] h400;
		q100 = div25(y[11:2]);
		q400 = div25({2'b00, y[11:4]});
		h100 = 12'({6'd0, q100} * 12'd100);
		h400 = 12'({6'd0, q400} * 12'd400);
		return (y[1:0] == 2'b00 && y != h100) || y == h400;
	endfunction

	function automatic day_t dim(input month_t m, input year_t y);
		return (m == 4'd2 && leap(y)) ? 5'd29 : MONTH_LEN[m];
	endfunction

	function automatic dnum_t leaps_to(input year_t x);
		logic [9:0] q4;
		q4 = x[11:2];
		return 18'(q4) - 18'(div25(q4)) + 18'(div25({2'b00, x[11:4]}));
	endfunction

	localparam dnum_t LEAPS_BASE = leaps_to(year_t'(BASE_YEAR - 1));

	function automatic dnum_t days_before(input off_t off);
		year_t y;
		y = year_t'(BASE_YEAR) + year_t'(off);
		return 18'(off) * 18'd365 + leaps_to(y - 12'd1) - LEAPS_BASE;
	endfunction

	function automatic doy_t doy(input day_t d, input month_t m, input year_t y);
		return 9'(d) + CUM_DAYS[m] + 9'(leap(y) && m > 4'd2);
	endfunction

	function automatic dnum_t daynum(input day_t d, input month_t m, input year_t y);
		return days_before(off_t'(y - year_t'(BASE_YEAR))) + 18'(doy(d, m, y));
	endfunction

	function automatic logic valid(input day_t d, input month_t m, input year_t y);
		return y >= year_t'(BASE_YEAR) && y <= year_t'(LAST_YEAR) && m >= 4'd1 && m <= 4'd12
			&& d >= 5'd1 && d <= dim(m, y);
	endfunction

	function automatic day_t ref_d();
		day_t l;
		l = dim(month_t'(REF_MONTH), year_t'(BASE_YEAR));
		if (l == 5'd0)
			return 5'd1;
		return (day_t'(REF_DAY) > l) ? l : day_t'(REF_DAY);
	endfunction

	localparam day_t  REF_D   = ref_d();
	localparam dnum_t MAX_DN  = daynum(5'd31, 4'd12, year_t'(LAST_YEAR));
	localparam dnum_t REF_DN  = daynum(REF_D, month_t'(REF_MONTH), year_t'(BASE_YEAR));
	// multiple of seven above any reference offset keeps the weekday non-negative
	localparam dnum_t WK_BIAS = 18'd371 - REF_DN;

	// x mod 7 for x below 2**17, by reciprocal
	function automatic wday_t mod7(input dnum_t x);
		logic [35:0] p;
		logic [14:0] q;
		logic [17:0] r;
		p = {18'd0, x} * 36'd149797;
		q = p[34:20];
		r = x - 18'({3'd0, q} * 18'd7);
		return r[2:0];
	endfunction

endpackage

// File: rtl/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
// channel  signals                                          direction
// in       in_valid in_ready opcode in_day in_month          sink
//          in_year day_count
// out      out_valid out_ready ok cur_day cur_month cur_year source
//          day_of_year day_number weekday difference
//
// each item passes through the load, held-date, given-date and execute states, then, for add and subtract, a year walk
// and a month walk run by the walk sequencer, then a final held-date step and the output state
// arst_n low puts the held date at the reference date and empties the output
// a new item is taken while the last result still waits in the output register;
// a stalled output holds the block in its last state until the result is taken
module calendar_date_arithmetic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cda_pkg::op_t         opcode,
	input  cda_pkg::day_t        in_day,
	input  cda_pkg::month_t      in_month,
	input  cda_pkg::year_t       in_year,
	input  cda_pkg::cnt_t        day_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ok,
	output cda_pkg::day_t        cur_day,
	output cda_pkg::month_t      cur_month,
	output cda_pkg::year_t       cur_year,
	output cda_pkg::doy_t        day_of_year,
	output cda_pkg::dnum_t       day_number,
	output cda_pkg::wday_t       weekday,
	output cda_pkg::diff_t       difference
);
	import cda_pkg::*;

	cda_cmd_t    cmd;
	cda_status_t st;

	cda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	cda_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.opcode      (opcode),
		.in_day      (in_day),
		.in_month    (in_month),
		.in_year     (in_year),
		.day_count   (day_count),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.cur_day     (cur_day),
		.cur_month   (cur_month),
		.cur_year    (cur_year),
		.day_of_year (day_of_year),
		.day_number  (day_number),
		.weekday     (weekday),
		.difference  (difference)
	);

endmodule

// File: rtl/cda_ctrl.sv
`timescale 1ns / 1ps
module cda_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cda_pkg::cda_status_t st,
	output cda_pkg::cda_cmd_t    cmd
);
	import cda_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HELD  = 3'd1;
	localparam logic [2:0] S_GIVEN = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_YEAR  = 3'd4;
	localparam logic [2:0] S_MONTH = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_HELD;
				end
			end
			S_HELD: begin
				cmd.calc_held = 1'b1;
				state_d = S_GIVEN;
			end
			S_GIVEN: begin
				cmd.calc_given = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = st.conv ? S_YEAR : S_FIN;
			end
			S_YEAR: begin
				cmd.year_step = 1'b1;
				if (st.year_done)
					state_d = S_MONTH;
			end
			S_MONTH: begin
				cmd.month_step = 1'b1;
				if (st.month_done)
					state_d = S_FIN;
			end
			S_FIN: begin
				cmd.calc_held = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_year_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_YEAR |-> $past(state_q) == S_EXEC || $past(state_q) == S_YEAR)
		else $error("year walk entered out of order");
	a_one_hot_cmd: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one command");
	a_publish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> state_q == S_IDLE)
		else $error("no return to idle after publish");

endmodule

// File: rtl/cda_dp.sv
`timescale 1ns / 1ps
module cda_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cda_pkg::cda_cmd_t    cmd,
	output cda_pkg::cda_status_t st,
	input  cda_pkg::op_t         opcode,
	input  cda_pkg::day_t        in_day,
	input  cda_pkg::month_t      in_month,
	input  cda_pkg::year_t       in_year,
	input  cda_pkg::cnt_t        day_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ok,
	output cda_pkg::day_t        cur_day,
	output cda_pkg::month_t      cur_month,
	output cda_pkg::year_t       cur_year,
	output cda_pkg::doy_t        day_of_year,
	output cda_pkg::dnum_t       day_number,
	output cda_pkg::wday_t       weekday,
	output cda_pkg::diff_t       difference
);
	import cda_pkg::*;

	op_t    op_q;
	day_t   gday_q;
	month_t gmonth_q;
	year_t  gyear_q;
	cnt_t   cnt_q;
	day_t   held_day_q;
	month_t held_month_q;
	year_t  held_year_q;
	dnum_t  dn_q;
	dnum_t  gdn_q;
	logic   gvalid_q;
	logic   ok_q;
	diff_t  diff_q;
	dnum_t  n_q;
	off_t   k_q;
	month_t m_q;
	logic   out_valid_q;

	dnum_t  sum;
	dnum_t  target;
	logic   t_ok;
	logic [34:0] est_p;
	off_t   est;
	year_t  walk_year;
	dnum_t  rem;
	day_t   mlen;

	assign sum = dn_q + 18'(cnt_q);
	assign walk_year = year_t'(BASE_YEAR) + year_t'(k_q);
	assign rem = n_q - days_before(k_q);
	assign mlen = dim(m_q, walk_year);

	always_comb begin
		target = sum;
		t_ok = 1'b1;
		if (op_q == OP_ADD) begin
			if (sum > MAX_DN) begin
				target = MAX_DN;
				t_ok = 1'b0;
			end
		end else begin
			if (18'(cnt_q) >= dn_q) begin
				target = 18'd1;
				t_ok = 1'b0;
			end else begin
				target = dn_q - 18'(cnt_q);
			end
		end
	end

	// year estimate from (n - 1) / 366, never above the true year
	assign est_p = {18'd0, 17'(target - 18'd1)} * 35'd183357;
	assign est = (est_p[34:26] > off_t'(YEAR_SPAN - 1)) ? off_t'(YEAR_SPAN - 1) : est_p[34:26];

	assign st.conv = (op_q == OP_ADD) || (op_q == OP_SUB);
	assign st.year_done = !(k_q < off_t'(YEAR_SPAN - 1) && rem > (leap(walk_year) ? 18'd366 : 18'd365));
	assign st.month_done = !(m_q < 4'd12 && n_q > 18'(mlen));
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			gday_q <= in_day;
			gmonth_q <= in_month;
			gyear_q <= in_year;
			cnt_q <= day_count;
		end
		if (cmd.calc_held)
			dn_q <= daynum(held_day_q, held_month_q, held_year_q);
		if (cmd.calc_given) begin
			gdn_q <= daynum(gday_q, gmonth_q, gyear_q);
			gvalid_q <= valid(gday_q, gmonth_q, gyear_q);
		end
		if (cmd.exec) begin
			diff_q <= (op_q == OP_CMP && gvalid_q) ? diff_t'(dn_q) - diff_t'(gdn_q) : '0;
			n_q <= target;
			k_q <= est;
			unique case (op_q)
				OP_ASSIGN: ok_q <= gvalid_q;
				OP_ADD, OP_SUB: ok_q <= t_ok;
				OP_CMP: ok_q <= gvalid_q;
				default: ok_q <= 1'b0;
			endcase
		end
		if (cmd.year_step) begin
			if (st.year_done) begin
				n_q <= rem;
				m_q <= 4'd1;
			end else begin
				k_q <= k_q + 9'd1;
			end
		end
		if (cmd.month_step && !st.month_done) begin
			n_q <= n_q - 18'(mlen);
			m_q <= m_q + 4'd1;
		end
		if (cmd.publish) begin
			ok <= ok_q;
			cur_day <= held_day_q;
			cur_month <= held_month_q;
			cur_year <= held_year_q;
			day_of_year <= doy(held_day_q, held_month_q, held_year_q);
			day_number <= dn_q;
			weekday <= mod7(dn_q + WK_BIAS);
			difference <= diff_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_day_q <= REF_D;
			held_month_q <= month_t'(REF_MONTH);
			held_year_q <= year_t'(BASE_YEAR);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && op_q == OP_ASSIGN && gvalid_q) begin
				held_day_q <= gday_q;
				held_month_q <= gmonth_q;
				held_year_q <= gyear_q;
			end
			if (cmd.month_step && st.month_done) begin
				held_day_q <= n_q[4:0];
				held_month_q <= m_q;
				held_year_q <= walk_year;
			end
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_month_q >= 4'd1 && held_month_q <= 4'd12)
		else $error("held month out of range");
	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_year_q >= year_t'(BASE_YEAR) && held_year_q <= year_t'(LAST_YEAR))
		else $error("held year out of span");
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> out_valid_q)
		else $error("result not shown after publish");

endmodule
